// ===== hdl/gtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_pkg
// Shared types, status codes and calendar helpers for the GPS time to UTC
// seconds converter.
// ----------------------------------------------------------------------------
package gtu_pkg;

    localparam logic [7:0]  ASCII_ZERO   = 8'd48;
    localparam logic [7:0]  ASCII_NINE   = 8'd57;
    localparam logic [7:0]  FIX_VALID    = 8'd65;
    localparam logic [7:0]  LOCK_BYTE_OK = 8'd1;
    // days from 1970-01-01 to 2000-01-01
    localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    localparam logic [2:0] ST_UPDATED    = 3'd0;
    localparam logic [2:0] ST_RX_FAIL    = 3'd1;
    localparam logic [2:0] ST_PPS_UNLOCK = 3'd2;
    localparam logic [2:0] ST_NO_FIX     = 3'd3;
    localparam logic [2:0] ST_BAD_DIGITS = 3'd4;

    typedef struct packed {
        logic        packet_ok;
        logic [7:0]  pps_lock_byte;
        logic [7:0]  fix_status_char;
        logic [47:0] date_chars;
        logic [47:0] time_chars;
    } t_in_data;

    typedef struct packed {
        logic [2:0]  status;
        logic        pps_ok;
        logic        fix_ok;
        logic [31:0] utc_seconds;
    } t_out_data;

    // per-request decision handed from the converter to the output stage
    typedef struct packed {
        logic [2:0]  status;
        logic        pps_clr;
        logic        fix_clr;
        logic        flags_set;
        logic        load;
        logic [31:0] secs;
    } t_conv;

    // days from 1970 to Jan 1 of year 2000+yy; 2000 is a leap year and
    // 2100 is out of range, so every fourth year is leap
    function automatic logic [15:0] year_start(input logic [6:0] yy);
        logic [15:0] lin;
        logic [15:0] leaps;
        begin
            lin   = 16'(yy) * 16'd365;
            leaps = 16'((8'(yy) + 8'd3) >> 2);
            return DAYS_TO_2000 + lin + leaps;
        end
    endfunction

    // day of year (from 0) of the first of the month
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        begin
            case (m)
                4'd1:    base = 9'd0;
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && m > 4'd2) begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

// ===== hdl/gps_time_to_utc_seconds.sv =====
`timescale 1ns / 1ps
// Path: a request is accepted into the input register, converted combinationally,
// then captured in the result register that drives the output channel.
// Throughput: one request per cycle, set by the single pass through the digit
// check and the days-times-86400 multiplier; a stalled result holds the input.
// Reset (synchronous, active low) empties both registers and clears the PPS
// flag, the fix flag and the held second count.
// ----------------------------------------------------------------------------
// gps_time_to_utc_seconds
// Turns GPS sync requests (lock, fix, ASCII date and time) into held Unix
// seconds plus PPS and fix status.
// ----------------------------------------------------------------------------
module gps_time_to_utc_seconds
    import gtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_data  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_data o_data
);

    logic     r_in_valid;
    t_in_data r_in;
    t_conv    conv;
    logic     take;

    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    gtu_conv u_conv (
        .i_req  (r_in),
        .o_conv (conv)
    );

    gtu_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_conv  (conv),
        .o_take  (take),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== hdl/gtu_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_conv
// Checks one sync request and turns its date and time digits into Unix
// seconds. Pure combinational; sits between the input and result registers.
// ----------------------------------------------------------------------------
module gtu_conv
    import gtu_pkg::*;
(
    input  t_in_data i_req,
    output t_conv    o_conv
);

    logic [3:0]  d [6];
    logic [3:0]  t [6];
    logic [11:0] digit_ok;
    logic [6:0]  yy;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hh;
    logic [6:0]  mm;
    logic [6:0]  ss;
    logic        month_ok;
    logic [15:0] days;
    logic [31:0] day_secs;
    logic [31:0] tod_secs;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            d[k] = i_req.date_chars[8*k +: 4];
            t[k] = i_req.time_chars[8*k +: 4];
            digit_ok[k]     = (i_req.date_chars[8*k +: 8] >= ASCII_ZERO) &&
                              (i_req.date_chars[8*k +: 8] <= ASCII_NINE);
            digit_ok[k + 6] = (i_req.time_chars[8*k +: 8] >= ASCII_ZERO) &&
                              (i_req.time_chars[8*k +: 8] <= ASCII_NINE);
        end
    end

    assign yy    = 7'(d[1]) * 7'd10 + 7'(d[0]);
    assign month = 7'(d[3]) * 7'd10 + 7'(d[2]);
    assign day   = 7'(d[5]) * 7'd10 + 7'(d[4]);
    assign hh    = 7'(t[5]) * 7'd10 + 7'(t[4]);
    assign mm    = 7'(t[3]) * 7'd10 + 7'(t[2]);
    assign ss    = 7'(t[1]) * 7'd10 + 7'(t[0]);

    assign month_ok = (month >= 7'd1) && (month <= 7'd12);

    // day 0 and days past month end roll over linearly
    assign days = year_start(yy) + 16'(month_start(month[3:0], yy[1:0] == 2'b00))
                + 16'(day) - 16'd1;
    // at most 47550 days, so the product stays below 2^32
    assign day_secs = 32'(days) * 32'(SECS_PER_DAY);
    assign tod_secs = 32'(hh) * 32'd3600 + 32'(mm) * 32'd60 + 32'(ss);

    always_comb begin
        o_conv.pps_clr   = 1'b0;
        o_conv.fix_clr   = 1'b0;
        o_conv.flags_set = 1'b0;
        o_conv.load      = 1'b0;
        o_conv.secs      = day_secs + tod_secs;
        if (!i_req.packet_ok) begin
            o_conv.status  = ST_RX_FAIL;
            o_conv.fix_clr = 1'b1;
        end else if (i_req.pps_lock_byte != LOCK_BYTE_OK) begin
            o_conv.status  = ST_PPS_UNLOCK;
            o_conv.pps_clr = 1'b1;
        end else if (i_req.fix_status_char != FIX_VALID) begin
            o_conv.status  = ST_NO_FIX;
            o_conv.fix_clr = 1'b1;
        end else if (!(&digit_ok) || !month_ok) begin
            o_conv.status    = ST_BAD_DIGITS;
            o_conv.flags_set = 1'b1;
        end else begin
            o_conv.status    = ST_UPDATED;
            o_conv.flags_set = 1'b1;
            o_conv.load      = 1'b1;
        end
    end

endmodule

// ===== hdl/gtu_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_out_stage
// Holds the PPS and fix flags and the UTC second count, and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module gtu_out_stage
    import gtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_conv     i_conv,
    output logic      o_take,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_data o_data
);

    logic        r_pps;
    logic        r_fix;
    logic [31:0] r_held;
    logic        r_valid;
    t_out_data   r_data;
    logic        n_pps;
    logic        n_fix;
    logic [31:0] n_held;
    logic        take;

    assign take = i_valid && (!r_valid || i_ready);

    always_comb begin
        n_pps  = r_pps;
        n_fix  = r_fix;
        n_held = r_held;
        if (i_conv.pps_clr) begin
            n_pps = 1'b0;
        end
        if (i_conv.fix_clr) begin
            n_fix = 1'b0;
        end
        if (i_conv.flags_set) begin
            n_pps = 1'b1;
            n_fix = 1'b1;
        end
        if (i_conv.load) begin
            n_held = i_conv.secs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pps   <= 1'b0;
            r_fix   <= 1'b0;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pps  <= n_pps;
                r_fix  <= n_fix;
                r_held <= n_held;
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data.status      <= i_conv.status;
            r_data.pps_ok      <= n_pps;
            r_data.fix_ok      <= n_fix;
            r_data.utc_seconds <= n_held;
        end
    end

    assign o_take  = take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/gtu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtu_checker
// Port-level checks on the converter's results, bound to the top level.
// ----------------------------------------------------------------------------
module gtu_checker
    import gtu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_data o_data
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_update_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_UPDATED || o_data.status == ST_BAD_DIGITS)
            |-> o_data.pps_ok && o_data.fix_ok)
        else $error("flags not set on a locked fix");

    a_fail_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_RX_FAIL || o_data.status == ST_NO_FIX)
            |-> !o_data.fix_ok)
        else $error("fix flag kept after a failure");

    a_unlock_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_PPS_UNLOCK |-> !o_data.pps_ok)
        else $error("pps flag kept while unlocked");

endmodule

bind gps_time_to_utc_seconds gtu_checker u_gtu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== tb/gps_time_to_utc_seconds_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_time_to_utc_seconds_tb
// Self-checking bench for the GPS sync request to UTC seconds converter.
// A short table of directed requests is followed by random ones. Every
// accepted request is run through a local model of the PPS/fix flags and
// the calendar conversion. Each result is checked field by field against
// the oldest pending expectation. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module gps_time_to_utc_seconds_tb;
    import gtu_pkg::*;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int LONG_HOLD_CYCLES = 80;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_data  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_data o_data;

    gps_time_to_utc_seconds DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    typedef struct {
        logic        pkt;
        logic [7:0]  lock;
        logic [7:0]  fix;
        logic [47:0] date;
        logic [47:0] tod;
        bit          typed;
        t_out_data   want;
    } t_sync_row;

    t_sync_row sync_rows[$];
    t_out_data utc_pending_q[$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        requests_sent = 0;

    // local copy of the converter state
    logic        pps_flag;
    logic        fix_flag;
    logic [31:0] held_utc;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // days from 1970-01-01 to the first of the given month
    function automatic longint days_to_month(input int year, input int month);
        int     mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        longint days;
        int     y;
        int     m;
        days = 0;
        for (y = 1970; y < year; y++) begin
            days += leap_year(y) ? 366 : 365;
        end
        for (m = 1; m < month; m++) begin
            days += mdays[m - 1] + ((m == 2 && leap_year(year)) ? 1 : 0);
        end
        return days;
    endfunction

    function automatic t_out_data predict_utc(input t_in_data req);
        t_out_data  res;
        logic [7:0] c;
        int         dig[12];
        bit         digits_ok;
        int         month;
        int         k;
        longint     secs;
        res.status = ST_UPDATED;
        if (!req.packet_ok) begin
            fix_flag   = 1'b0;
            res.status = ST_RX_FAIL;
        end else if (req.pps_lock_byte != LOCK_BYTE_OK) begin
            pps_flag   = 1'b0;
            res.status = ST_PPS_UNLOCK;
        end else if (req.fix_status_char != FIX_VALID) begin
            fix_flag   = 1'b0;
            res.status = ST_NO_FIX;
        end else begin
            pps_flag  = 1'b1;
            fix_flag  = 1'b1;
            digits_ok = 1'b1;
            for (k = 0; k < 6; k++) begin
                c = req.date_chars[8*k +: 8];
                if (c < ASCII_ZERO || c > ASCII_NINE) digits_ok = 1'b0;
                dig[k] = int'(c) - int'(ASCII_ZERO);
                c = req.time_chars[8*k +: 8];
                if (c < ASCII_ZERO || c > ASCII_NINE) digits_ok = 1'b0;
                dig[6 + k] = int'(c) - int'(ASCII_ZERO);
            end
            month = dig[3] * 10 + dig[2];
            if (!digits_ok || month < 1 || month > 12) begin
                res.status = ST_BAD_DIGITS;
            end else begin
                // day 0 or past month end rolls over linearly
                secs = (days_to_month(2000 + dig[1] * 10 + dig[0], month)
                        + dig[5] * 10 + dig[4] - 1) * 86400
                     + (dig[11] * 10 + dig[10]) * 3600
                     + (dig[9] * 10 + dig[8]) * 60
                     + dig[7] * 10 + dig[6];
                held_utc = secs[31:0];
            end
        end
        res.pps_ok      = pps_flag;
        res.fix_ok      = fix_flag;
        res.utc_seconds = held_utc;
        return res;
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        return ASCII_ZERO + 8'(v);
    endfunction

    function automatic logic [47:0] two_digit_fields(input int a, input int b, input int c);
        return {digit_char(a / 10), digit_char(a % 10), digit_char(b / 10),
                digit_char(b % 10), digit_char(c / 10), digit_char(c % 10)};
    endfunction

    function automatic logic [47:0] random_digits();
        logic [47:0] v;
        int          k;
        for (k = 0; k < 6; k++) begin
            v[8*k +: 8] = digit_char($urandom_range(0, 9));
        end
        return v;
    endfunction

    function automatic t_in_data make_request();
        t_in_data req;
        int       kind;
        int       pos;
        kind                = $urandom_range(0, 99);
        req.packet_ok       = 1'b1;
        req.pps_lock_byte   = LOCK_BYTE_OK;
        req.fix_status_char = FIX_VALID;
        if ($urandom_range(0, 6) == 0) begin
            // any digit anywhere: month 00/13..99, day 0, hour/second past range
            req.date_chars = random_digits();
            req.time_chars = random_digits();
        end else begin
            req.date_chars = two_digit_fields($urandom_range(1, 31), $urandom_range(1, 12),
                                              $urandom_range(0, 99));
            req.time_chars = two_digit_fields($urandom_range(0, 23), $urandom_range(0, 59),
                                              ($urandom_range(0, 9) == 0) ?
                                              $urandom_range(60, 99) : $urandom_range(0, 59));
        end
        if (kind >= 70 && kind < 78) begin
            req.packet_ok       = 1'b0;
            req.pps_lock_byte   = 8'($urandom());
            req.fix_status_char = 8'($urandom());
            req.date_chars      = 48'({$urandom(), $urandom()});
        end else if (kind >= 78 && kind < 85) begin
            req.pps_lock_byte = 8'($urandom());
        end else if (kind >= 85 && kind < 91) begin
            req.fix_status_char = ($urandom_range(0, 1) == 0) ? 8'($urandom()) : 8'h56;
        end else if (kind >= 91 && kind < 96) begin
            pos = $urandom_range(0, 5);
            if ($urandom_range(0, 1) == 0) req.date_chars[8*pos +: 8] = 8'($urandom());
            else req.time_chars[8*pos +: 8] = 8'($urandom());
        end else if (kind >= 96) begin
            req.date_chars = 48'({$urandom(), $urandom()});
            req.time_chars = 48'({$urandom(), $urandom()});
        end
        return req;
    endfunction

    task automatic add_row(input logic pkt, input logic [7:0] lock, input logic [7:0] fix,
                           input logic [47:0] date, input logic [47:0] tod,
                           input bit typed, input t_out_data want);
        t_sync_row row;
        row = '{pkt, lock, fix, date, tod, typed, want};
        sync_rows.insert(sync_rows.size(), row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high so a back-to-back request needs no extra toggle
    task automatic send_request(input t_in_data req, input bit typed, input t_out_data want);
        int        gap;
        t_out_data predicted;
        gap = (requests_sent % 256 < 48) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = req;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_utc(req);
        utc_pending_q.insert(utc_pending_q.size(), typed ? want : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_in_data  req;
        t_out_data none;
        int        n;
        int        drain;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        i_ready  = 1'b0;
        pps_flag = 1'b0;
        fix_flag = 1'b0;
        held_utc = '0;
        none     = '0;

        add_row(1'b0, LOCK_BYTE_OK, FIX_VALID, "010100", "000000", 1,
                '{ST_RX_FAIL, 1'b0, 1'b0, 32'd0});
        add_row(1'b1, 8'h00, FIX_VALID, "010100", "000000", 1,
                '{ST_PPS_UNLOCK, 1'b0, 1'b0, 32'd0});
        add_row(1'b1, LOCK_BYTE_OK, 8'h56, "010100", "000000", 1,
                '{ST_NO_FIX, 1'b0, 1'b0, 32'd0});
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "010100", "000000", 1,
                '{ST_UPDATED, 1'b1, 1'b1, 32'd946684800});
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "311299", "235959", 1,
                '{ST_UPDATED, 1'b1, 1'b1, 32'd4102444799});
        // month zero and thirteen keep the held value
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "010000", "120000", 1,
                '{ST_BAD_DIGITS, 1'b1, 1'b1, 32'd4102444799});
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "011300", "000000", 1,
                '{ST_BAD_DIGITS, 1'b1, 1'b1, 32'd4102444799});
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "999999", "000000", 0, none);
        // day zero rolls back into the previous year
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "000100", "000000", 1,
                '{ST_UPDATED, 1'b1, 1'b1, 32'd946598400});
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "991299", "000000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "150625", "999999", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "290224", "123456", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "290223", "000000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "311299", "000060", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "010170", "000000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "01/100", "000000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, "010100", "00:000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, 48'h0, 48'h0, 0, none);
        add_row(1'b1, LOCK_BYTE_OK, FIX_VALID, {6{8'hFF}}, {6{8'hFF}}, 0, none);
        add_row(1'b0, 8'hFF, 8'hFF, {6{8'hFF}}, {6{8'hFF}}, 0, none);
        add_row(1'b1, 8'hFF, FIX_VALID, "010100", "000000", 0, none);
        add_row(1'b1, 8'h02, FIX_VALID, "010100", "000000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, 8'h61, "010100", "000000", 0, none);
        add_row(1'b1, LOCK_BYTE_OK, 8'h00, "010100", "000000", 0, none);
        add_row(1'b0, LOCK_BYTE_OK, FIX_VALID, "AB/:CD", "000000", 0, none);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (sync_rows[n]) begin
            req.packet_ok       = sync_rows[n].pkt;
            req.pps_lock_byte   = sync_rows[n].lock;
            req.fix_status_char = sync_rows[n].fix;
            req.date_chars      = sync_rows[n].date;
            req.time_chars      = sync_rows[n].tod;
            send_request(req, sync_rows[n].typed, sync_rows[n].want);
        end

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) begin
                // let the pipeline drain completely once
                i_valid = 1'b0;
                while (utc_pending_q.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            send_request(make_request(), 0, none);
        end
        i_valid = 1'b0;

        drain = 0;
        while (utc_pending_q.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        if (utc_pending_q.size() != 0) begin
            report_mismatch("results never delivered", 0, utc_pending_q.size());
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        bit held_long;
        held_long = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (!held_long && results_seen >= 200) begin
                // long back-pressure so the input side fills and stalls
                held_long = 1'b1;
                stall     = LONG_HOLD_CYCLES;
            end else if (results_seen % 300 < 60) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
            end
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_data want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (utc_pending_q.size() == 0) begin
                report_mismatch("result with no request pending", o_data.utc_seconds, 0);
            end else begin
                want = utc_pending_q.pop_front();
                if (o_data.status !== want.status)
                    report_mismatch("status", o_data.status, want.status);
                if (o_data.pps_ok !== want.pps_ok)
                    report_mismatch("pps_ok", o_data.pps_ok, want.pps_ok);
                if (o_data.fix_ok !== want.fix_ok)
                    report_mismatch("fix_ok", o_data.fix_ok, want.fix_ok);
                if (o_data.utc_seconds !== want.utc_seconds)
                    report_mismatch("utc_seconds", o_data.utc_seconds, want.utc_seconds);
            end
        end
    end

endmodule

// ===== sim.f =====
hdl/gtu_pkg.sv
hdl/gtu_conv.sv
hdl/gtu_out_stage.sv
hdl/gps_time_to_utc_seconds.sv
hdl/gtu_checker.sv
tb/gps_time_to_utc_seconds_tb.sv
